/* src/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Each macro expects a signal named aclk, and FLOG2_ASSERT also aresetn, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define FLOG2_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("flog2 check failed");

// Clocked assertion that is also checked during reset.
`define FLOG2_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("flog2 check failed");

`endif

/* src/flog2_pkg.sv */
// Package for the float log2 fixed point unit: field widths, constants, stage type.
// No dependencies.
package flog2_pkg;

    localparam int IN_W              = 32;
    localparam int EXP_W             = 8;
    localparam int MAN_W             = 23;
    localparam int EXP_LSB           = MAN_W;
    localparam int OUT_W             = 17;
    localparam int OUT_TDATA_W       = 24;
    localparam int FRAC_BITS_DEFAULT = 8;
    localparam int EXP_BIAS          = 127;
    localparam int EXP_S_W           = EXP_W + 2;

    typedef struct packed {
        logic [EXP_W-1:0] expo;
        logic [MAN_W:0]   man;
    } stage_t;

endpackage

/* src/flog2_cell.sv */
// One squaring cell: squares the 1.23 mantissa and appends one fraction bit.
// Depends on flog2_pkg.
module flog2_cell #(
    parameter int FRAC_BITS = flog2_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  flog2_pkg::stage_t     in_stage,
    input  logic [FRAC_BITS-1:0]  in_frac,
    output logic                  out_valid,
    input  logic                  out_ready,
    output flog2_pkg::stage_t     out_stage,
    output logic [FRAC_BITS-1:0]  out_frac
);

    localparam int MW = flog2_pkg::MAN_W;

    logic                 valid_reg;
    logic                 valid_next;
    flog2_pkg::stage_t    stage_reg;
    flog2_pkg::stage_t    stage_next;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac_next;
    logic [2*MW+1:0]      square;
    logic [MW+1:0]        square_sh;
    logic                 bit_set;
    logic [FRAC_BITS:0]   frac_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign square    = {{(MW+1){1'b0}}, in_stage.man} * {{(MW+1){1'b0}}, in_stage.man};
    assign square_sh = square[2*MW+1:MW];
    assign bit_set   = square_sh[MW+1];
    assign frac_ext  = {in_frac, bit_set};

    always_comb begin
        valid_next      = in_ready ? in_valid : valid_reg;
        stage_next      = stage_reg;
        frac_next       = frac_reg;
        if (in_valid && in_ready) begin
            stage_next.expo = in_stage.expo;
            stage_next.man  = bit_set ? square_sh[MW+1:1] : square_sh[MW:0];
            frac_next       = frac_ext[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        stage_reg <= stage_next;
        frac_reg  <= frac_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;
    assign out_frac  = frac_reg;

endmodule

/* src/float_log2_fixed_point_unit.sv */
// Top level of the float log2 fixed point unit: a row of squaring cells and an output register.
// Depends on flog2_pkg and flog2_cell.
//
// Use: a single-precision float pattern enters on the s_ channel, and log2 of its
// magnitude leaves on the m_ channel as a 17-bit two's-complement value with
// FRAC_BITS fraction bits. The integer part is the exponent field minus 127; zero,
// denormals, infinity and NaN are not flagged.
// Latency: FRAC_BITS + 1 register stages, one in each squaring cell and the output
// register. The first cell loads at the input transfer, and each item then passes
// through every later cell and the output register before m_tvalid rises for it.
// Throughput: one transfer per cycle while m_tready stays high; each cell holds one
// 24 by 24 multiplier, and the row of cells forms the pipeline.
// Stall: every cell takes a new item when it is empty or its neighbor takes its item,
// so bubbles close up and inputs keep being accepted while a result waits, until
// every cell is full.
// Reset: aresetn low for one clock empties all cells and the output register.
module float_log2_fixed_point_unit #(
    parameter int FRAC_BITS = flog2_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [flog2_pkg::IN_W-1:0]        s_tdata,  // [31:0] float_bits
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [flog2_pkg::OUT_TDATA_W-1:0] m_tdata   // [16:0] log2_value, rest zero
);

    localparam int ACC_W = flog2_pkg::EXP_S_W + FRAC_BITS;

    logic                 cell_valid [0:FRAC_BITS];
    logic                 cell_ready [0:FRAC_BITS];
    flog2_pkg::stage_t    cell_stage [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] cell_frac  [0:FRAC_BITS];

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [flog2_pkg::OUT_W-1:0]   result_reg;
    logic signed [flog2_pkg::OUT_W-1:0]   result_next;
    logic signed [flog2_pkg::EXP_S_W-1:0] exp_s;
    logic signed [ACC_W-1:0]              acc;

    assign cell_valid[0]      = s_tvalid;
    assign s_tready           = cell_ready[0];
    assign cell_stage[0].expo = s_tdata[flog2_pkg::EXP_LSB +: flog2_pkg::EXP_W];
    assign cell_stage[0].man  = {1'b1, s_tdata[flog2_pkg::MAN_W-1:0]};
    assign cell_frac[0]       = '0;

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
        flog2_cell #(
            .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_stage  (cell_stage[i]),
            .in_frac   (cell_frac[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_stage (cell_stage[i+1]),
            .out_frac  (cell_frac[i+1])
        );
    end

    assign cell_ready[FRAC_BITS] = !out_valid_reg || m_tready;

    assign exp_s = $signed({2'b00, cell_stage[FRAC_BITS].expo})
                 - flog2_pkg::EXP_S_W'(flog2_pkg::EXP_BIAS);
    assign acc   = {exp_s, cell_frac[FRAC_BITS]};

    always_comb begin
        out_valid_next = cell_ready[FRAC_BITS] ? cell_valid[FRAC_BITS] : out_valid_reg;
        result_next    = result_reg;
        if (cell_valid[FRAC_BITS] && cell_ready[FRAC_BITS]) begin
            result_next = flog2_pkg::OUT_W'(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(flog2_pkg::OUT_TDATA_W - flog2_pkg::OUT_W){1'b0}}, result_reg};

endmodule

/* src/flog2_checker.sv */
// Port-level checker for the float log2 fixed point unit, bound to its top level.
// Depends on flog2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flog2_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [flog2_pkg::IN_W-1:0]        s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [flog2_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // A ready receiver lets every cell advance, so the input side is ready too.
    `FLOG2_ASSERT_ALWAYS(a_ready_flows, m_tready |-> s_tready)
    // Reset empties the output register.
    `FLOG2_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)
    // The bits above the 17-bit result are always zero.
    `FLOG2_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[flog2_pkg::OUT_TDATA_W-1:flog2_pkg::OUT_W] == 0)
    `FLOG2_ASSERT(a_stall_valid, m_tvalid && !m_tready |=> m_tvalid)
    `FLOG2_ASSERT(a_stall_data, m_tvalid && !m_tready |=> $stable(m_tdata))

endmodule

bind float_log2_fixed_point_unit flog2_port_checker u_flog2_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
